// ===== rtl/core/bqf_pkg.sv =====
package bqf_pkg;

    localparam int NUM_COEFS = 5;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        COEF_B0 = 3'd0,
        COEF_B1 = 3'd1,
        COEF_B2 = 3'd2,
        COEF_A1 = 3'd3,
        COEF_A2 = 3'd4
    } t_coef_idx;

    // a1 reset gain is 0x7FFF / 0x8000 in coefficient format
    localparam longint A1_RST_NUM = 64'sh7FFF;
    localparam longint A1_RST_DEN = 64'sh8000;

    // tuser bit positions on the request side
    localparam int TUSER_PRESENT = 0;
    localparam int TUSER_WANTED  = 1;
    localparam int IN_TUSER_W    = 2;

endpackage

// ===== rtl/core/biquad_iir_filter.sv =====
// data path: each input request passes the input register, then the result register
// throughput: one sample per cycle while the master side accepts results; the
// multiply-accumulate with one-sample output feedback lies between the registers
// reset: synchronous active low; clears history and valid flags, loads default coefficients
module biquad_iir_filter
    import bqf_pkg::*;
#(
    parameter int SAMPLE_WIDTH   = 24,
    parameter int COEF_FRAC_BITS = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    // slave side
    input  logic                                    i_s_axis_tvalid,
    output logic                                    o_s_axis_tready,
    input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]       i_s_axis_tdata,  // sample_in
    input  logic [IN_TUSER_W-1:0]                   i_s_axis_tuser,  // input_present, output_wanted
    input  logic                                    i_s_axis_tlast,  // block_end
    // master side
    output logic                                    o_m_axis_tvalid,
    input  logic                                    i_m_axis_tready,
    output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]       o_m_axis_tdata,  // sample_out
    output logic [0:0]                              o_m_axis_tuser,  // filtered
    output logic                                    o_m_axis_tlast,  // block_end_out
    // configuration
    input  logic                                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]                    i_cfg_idx,
    input  logic [COEF_FRAC_BITS+1:0]               i_cfg_data
);

    localparam int SW     = SAMPLE_WIDTH;
    localparam int DATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;

    logic [NUM_COEFS-1:0][COEF_FRAC_BITS+1:0] w_coefs;

    logic                 r_in_valid;
    logic signed [SW-1:0] r_in_sample;
    logic                 r_in_present;
    logic                 r_in_wanted;
    logic                 r_in_last;

    logic signed [SW-1:0] r_x1, r_x2, r_y1, r_y2;

    logic                 r_out_valid;
    logic signed [SW-1:0] r_out_sample;
    logic                 r_out_filtered;
    logic                 r_out_last;

    logic                 w_out_free;
    logic                 w_advance;
    logic                 w_in_accept;
    logic signed [SW-1:0] w_y;

    bqf_coef_regs #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_coef_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_coefs    (w_coefs)
    );

    bqf_mac #(
        .SAMPLE_WIDTH   (SAMPLE_WIDTH),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_mac (
        .i_coefs (w_coefs),
        .i_x0    (r_in_sample),
        .i_x1    (r_x1),
        .i_x2    (r_x2),
        .i_y1    (r_y1),
        .i_y2    (r_y2),
        .o_y     (w_y)
    );

    assign w_out_free      = !r_out_valid || i_m_axis_tready;
    assign w_advance       = r_in_valid && w_out_free;
    assign o_s_axis_tready = !r_in_valid || w_out_free;
    assign w_in_accept     = i_s_axis_tvalid && o_s_axis_tready;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_in_sample  <= $signed(i_s_axis_tdata[SW-1:0]);
            r_in_present <= i_s_axis_tuser[TUSER_PRESENT];
            r_in_wanted  <= i_s_axis_tuser[TUSER_WANTED];
            r_in_last    <= i_s_axis_tlast;
        end
    end

    // filter history
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x1 <= '0;
            r_x2 <= '0;
            r_y1 <= '0;
            r_y2 <= '0;
        end else if (w_advance) begin
            if (r_in_wanted) begin
                r_y1 <= w_y;
                r_y2 <= r_y1;
            end
            if (r_in_present || r_in_wanted) begin
                r_x1 <= r_in_present ? r_in_sample : '0;
                r_x2 <= r_x1;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_sample   <= r_in_wanted ? w_y : r_in_sample;
            r_out_filtered <= r_in_wanted;
            r_out_last     <= r_in_last;
        end
    end

    assign o_m_axis_tvalid   = r_out_valid;
    assign o_m_axis_tdata    = DATA_W'($unsigned(r_out_sample));
    assign o_m_axis_tuser[0] = r_out_filtered;
    assign o_m_axis_tlast    = r_out_last;

    a_adv_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |=> o_m_axis_tvalid)
        else $error("result missing after advance");

    a_hist_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_advance |=> ($stable(r_x1) && $stable(r_x2) && $stable(r_y1) && $stable(r_y2)))
        else $error("history changed without a request");

    a_feedback_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && r_in_wanted) |=> (r_y1 == r_out_sample && r_out_filtered))
        else $error("output history differs from filtered result");

    a_zero_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && r_in_wanted && !r_in_present) |=> (r_x1 == '0))
        else $error("absent input did not shift zero into history");

    a_pass_through: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && !r_in_wanted) |=> (r_out_sample == $past(r_in_sample) && !r_out_filtered))
        else $error("pass-through sample altered");

endmodule

// ===== rtl/core/bqf_coef_regs.sv =====
module bqf_coef_regs
    import bqf_pkg::*;
#(
    parameter int COEF_FRAC_BITS = 16
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_cfg_we,
    input  logic [CFG_IDX_W-1:0]                        i_cfg_idx,
    input  logic [COEF_FRAC_BITS+1:0]                   i_cfg_data,
    output logic [NUM_COEFS-1:0][COEF_FRAC_BITS+1:0]    o_coefs
);

    localparam int     CW      = COEF_FRAC_BITS + 2;
    localparam longint ONE     = 64'sd1 <<< COEF_FRAC_BITS;
    localparam longint A1_RST  = (A1_RST_NUM <<< COEF_FRAC_BITS) / A1_RST_DEN;

    logic [NUM_COEFS-1:0][CW-1:0] r_coefs;
    logic [NUM_COEFS-1:0][CW-1:0] n_coefs;

    always_comb begin
        n_coefs = r_coefs;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                COEF_B0: n_coefs[COEF_B0] = i_cfg_data;
                COEF_B1: n_coefs[COEF_B1] = i_cfg_data;
                COEF_B2: n_coefs[COEF_B2] = i_cfg_data;
                COEF_A1: n_coefs[COEF_A1] = i_cfg_data;
                COEF_A2: n_coefs[COEF_A2] = i_cfg_data;
                default: n_coefs = r_coefs;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coefs[COEF_B0] <= CW'(ONE);
            r_coefs[COEF_B1] <= CW'(-ONE);
            r_coefs[COEF_B2] <= '0;
            r_coefs[COEF_A1] <= CW'(A1_RST);
            r_coefs[COEF_A2] <= '0;
        end else begin
            r_coefs <= n_coefs;
        end
    end

    assign o_coefs = r_coefs;

endmodule

// ===== rtl/core/bqf_mac.sv =====
module bqf_mac
    import bqf_pkg::*;
#(
    parameter int SAMPLE_WIDTH   = 24,
    parameter int COEF_FRAC_BITS = 16
) (
    input  logic [NUM_COEFS-1:0][COEF_FRAC_BITS+1:0]    i_coefs,
    input  logic signed [SAMPLE_WIDTH-1:0]              i_x0,
    input  logic signed [SAMPLE_WIDTH-1:0]              i_x1,
    input  logic signed [SAMPLE_WIDTH-1:0]              i_x2,
    input  logic signed [SAMPLE_WIDTH-1:0]              i_y1,
    input  logic signed [SAMPLE_WIDTH-1:0]              i_y2,
    output logic signed [SAMPLE_WIDTH-1:0]              o_y
);

    localparam int SW = SAMPLE_WIDTH;
    localparam int CW = COEF_FRAC_BITS + 2;
    localparam int PW = CW + SW;
    localparam int AW = PW + 3;
    localparam int QW = AW - COEF_FRAC_BITS;

    localparam logic signed [AW-1:0] RND = AW'(1) <<< (COEF_FRAC_BITS - 1);
    localparam logic signed [SW-1:0] MAXV = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] MINV = {1'b1, {(SW-1){1'b0}}};

    logic signed [CW-1:0] b0, b1, b2, a1, a2;
    logic signed [PW-1:0] p0, p1, p2, p3, p4;
    logic signed [AW-1:0] acc;
    logic signed [QW-1:0] q;
    logic                 in_range;

    assign b0 = $signed(i_coefs[COEF_B0]);
    assign b1 = $signed(i_coefs[COEF_B1]);
    assign b2 = $signed(i_coefs[COEF_B2]);
    assign a1 = $signed(i_coefs[COEF_A1]);
    assign a2 = $signed(i_coefs[COEF_A2]);

    assign p0 = PW'(b0) * PW'(i_x0);
    assign p1 = PW'(b1) * PW'(i_x1);
    assign p2 = PW'(b2) * PW'(i_x2);
    assign p3 = PW'(a1) * PW'(i_y1);
    assign p4 = PW'(a2) * PW'(i_y2);

    assign acc = AW'(p0) + AW'(p1) + AW'(p2) - AW'(p3) - AW'(p4) + RND;

    // floor shift, rounds half toward plus infinity with the offset above
    assign q = QW'(acc >>> COEF_FRAC_BITS);

    assign in_range = (&q[QW-1:SW-1]) || !(|q[QW-1:SW-1]);

    always_comb begin
        if (in_range) begin
            o_y = q[SW-1:0];
        end else if (q[QW-1]) begin
            o_y = MINV;
        end else begin
            o_y = MAXV;
        end
    end

endmodule
